@@ hw/rtl/lfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef logic [1:0] lfu_op_t;

  localparam lfu_op_t OP_NONE    = 2'd0;
  localparam lfu_op_t OP_GET_HIT = 2'd1;
  localparam lfu_op_t OP_SET_HIT = 2'd2;
  localparam lfu_op_t OP_INSERT  = 2'd3;

  // update broadcast to every cell
  typedef struct packed {
    lfu_op_t op;
    logic    evict;
  } lfu_cmd_t;

endpackage : lfu_pkg
`default_nettype wire

@@ hw/rtl/lfu_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_in_if
// Request channel: operation, key and value with valid/ready.
// ----------------------------------------------------------------------------
interface lfu_in_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface : lfu_in_if
`default_nettype wire

@@ hw/rtl/lfu_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_out_if
// Result channel: hit, read value and eviction report with valid/ready.
// ----------------------------------------------------------------------------
interface lfu_out_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface : lfu_out_if
`default_nettype wire

@@ hw/rtl/lfu_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry: key match, count and recency update, and one registered
// stage of the victim / free-slot chain.
// ----------------------------------------------------------------------------
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [KEY_BITS-1:0]    key_in,
  input  wire [VALUE_BITS-1:0]  value_in,
  input  lfu_cmd_t              cmd,
  input  wire [IDX_W-1:0]       ref_rank,
  input  wire [IDX_W-1:0]       vic_idx,
  input  wire [IDX_W-1:0]       ins_idx,
  // chain from previous cell
  input  wire                   bv_in,
  input  wire [COUNT_BITS-1:0]  bc_in,
  input  wire [IDX_W-1:0]       br_in,
  input  wire [IDX_W-1:0]       bi_in,
  input  wire [KEY_BITS-1:0]    bk_in,
  input  wire                   ff_in,
  input  wire [IDX_W-1:0]       fi_in,
  // chain to next cell
  output logic                  bv_out,
  output logic [COUNT_BITS-1:0] bc_out,
  output logic [IDX_W-1:0]      br_out,
  output logic [IDX_W-1:0]      bi_out,
  output logic [KEY_BITS-1:0]   bk_out,
  output logic                  ff_out,
  output logic [IDX_W-1:0]      fi_out,
  // match results, zero unless hit
  output logic                  hit_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [IDX_W-1:0]      rank_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                  valid_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [IDX_W-1:0]      rank_r;
  logic                  hit_r;

  logic                  bv_r, ff_r;
  logic [COUNT_BITS-1:0] bc_r;
  logic [IDX_W-1:0]      br_r, bi_r, fi_r;
  logic [KEY_BITS-1:0]   bk_r;
  logic                  take;

  assign take = valid_r && (!bv_in || (count_r < bc_in) ||
                            ((count_r == bc_in) && (rank_r > br_in)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
      ff_r <= 1'b0;
    end else begin
      bv_r <= bv_in || take;
      ff_r <= ff_in || !valid_r;
    end
    bc_r <= take ? count_r : bc_in;
    br_r <= take ? rank_r  : br_in;
    bi_r <= take ? MY_IDX  : bi_in;
    bk_r <= take ? key_r   : bk_in;
    fi_r <= ff_in ? fi_in  : MY_IDX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= valid_r && (key_r == key_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_GET_HIT: begin
          if (hit_r) begin
            if (count_r != {COUNT_BITS{1'b1}}) count_r <= count_r + 1'b1;
            rank_r <= '0;
          end else if (valid_r && rank_r < ref_rank) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        OP_SET_HIT: begin
          if (hit_r) begin
            value_r <= value_in;
            count_r <= '0;
            rank_r  <= '0;
          end else if (valid_r && rank_r < ref_rank) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        OP_INSERT: begin
          if (ins_idx == MY_IDX) begin
            valid_r <= 1'b1;
            key_r   <= key_in;
            value_r <= value_in;
            count_r <= '0;
            rank_r  <= '0;
          end else if (cmd.evict && vic_idx == MY_IDX) begin
            valid_r <= 1'b0;
          end else if (valid_r && !(cmd.evict && rank_r > ref_rank)) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign bv_out  = bv_r;
  assign bc_out  = bc_r;
  assign br_out  = br_r;
  assign bi_out  = bi_r;
  assign bk_out  = bk_r;
  assign ff_out  = ff_r;
  assign fi_out  = fi_r;
  assign hit_o   = hit_r;
  assign value_o = hit_r ? value_r : '0;
  assign rank_o  = hit_r ? rank_r  : '0;

endmodule : lfu_cell
`default_nettype wire

@@ hw/rtl/lfu_cache_lru_tiebreak.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// Fully associative LFU cache with LRU tie-break, built as a row of entry
// cells; the victim and first free slot ripple down a registered chain.
// ----------------------------------------------------------------------------
// A request passes the match and exec states; get and set on a present key
// register their result in exec. A set on a missing key waits in exec until
// the cell chain has settled after the last state update.
// One request at a time; the next is taken the cycle after the result is
// registered.
// Reset: valid bits and occupancy cleared, capacity_in_use = 16.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             cfg_wr_en,
  input  wire [CFG_W-1:0] cfg_wr_data,
  lfu_in_if.sink          in_ch,
  lfu_out_if.source       out_ch
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [OCC_W-1:0] SETTLED = OCC_W'(CAPACITY);
  localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      cap_r;
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      settle_r;
  logic                  req_mode_r;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [VALUE_BITS-1:0] req_value_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_evicted_r;
  logic [KEY_BITS-1:0]   out_ekey_r;

  // chain links
  logic [CAPACITY:0]     c_bv, c_ff;
  logic [COUNT_BITS-1:0] c_bc [CAPACITY+1];
  logic [IDX_W-1:0]      c_br [CAPACITY+1];
  logic [IDX_W-1:0]      c_bi [CAPACITY+1];
  logic [KEY_BITS-1:0]   c_bk [CAPACITY+1];
  logic [IDX_W-1:0]      c_fi [CAPACITY+1];

  logic [CAPACITY-1:0]   hit_vec;
  logic [VALUE_BITS-1:0] cell_val  [CAPACITY];
  logic [IDX_W-1:0]      cell_rank [CAPACITY];

  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_val;
  logic [IDX_W-1:0]      hit_rank;
  logic                  set_miss, go, do_evict, occ_ge_cap;
  logic [CMP_W-1:0]      cap_x, cap_eff;
  logic [IDX_W-1:0]      ins_idx, ref_rank;
  lfu_cmd_t              cmd;

  assign c_bv[0] = 1'b0;
  assign c_bc[0] = '0;
  assign c_br[0] = '0;
  assign c_bi[0] = '0;
  assign c_bk[0] = '0;
  assign c_ff[0] = 1'b0;
  assign c_fi[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lfu_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS),
      .IDX_W     (IDX_W),
      .IDX       (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .key_in  (req_key_r),
      .value_in(req_value_r),
      .cmd     (cmd),
      .ref_rank(ref_rank),
      .vic_idx (c_bi[CAPACITY]),
      .ins_idx (ins_idx),
      .bv_in   (c_bv[g]),
      .bc_in   (c_bc[g]),
      .br_in   (c_br[g]),
      .bi_in   (c_bi[g]),
      .bk_in   (c_bk[g]),
      .ff_in   (c_ff[g]),
      .fi_in   (c_fi[g]),
      .bv_out  (c_bv[g+1]),
      .bc_out  (c_bc[g+1]),
      .br_out  (c_br[g+1]),
      .bi_out  (c_bi[g+1]),
      .bk_out  (c_bk[g+1]),
      .ff_out  (c_ff[g+1]),
      .fi_out  (c_fi[g+1]),
      .hit_o   (hit_vec[g]),
      .value_o (cell_val[g]),
      .rank_o  (cell_rank[g])
    );
  end

  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_val  = hit_val  | cell_val[i];
      hit_rank = hit_rank | cell_rank[i];
    end
  end

  assign any_hit = |hit_vec;

  always_comb begin
    cap_x = CMP_W'(cap_r);
    if (cap_x == '0)          cap_eff = CMP_W'(1);
    else if (cap_x > CAP_MAX) cap_eff = CAP_MAX;
    else                      cap_eff = cap_x;
  end

  assign occ_ge_cap = CMP_W'(occ_r) >= cap_eff;
  assign set_miss   = req_mode_r && !any_hit;
  assign go         = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready) &&
                      (!set_miss || settle_r == SETTLED);
  assign do_evict   = set_miss && occ_ge_cap && c_bv[CAPACITY];
  // lowest free slot, counting the victim's slot once it is freed
  assign ins_idx    = (do_evict && (!c_ff[CAPACITY] || c_bi[CAPACITY] < c_fi[CAPACITY]))
                      ? c_bi[CAPACITY] : c_fi[CAPACITY];
  assign ref_rank   = any_hit ? hit_rank : c_br[CAPACITY];

  always_comb begin
    cmd.evict = do_evict;
    if (!go)          cmd.op = OP_NONE;
    else if (any_hit) cmd.op = req_mode_r ? OP_SET_HIT : OP_GET_HIT;
    else              cmd.op = req_mode_r ? OP_INSERT  : OP_NONE;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_EXEC;
      S_EXEC:  if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      settle_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (cmd.op == OP_INSERT) occ_r <= occ_r + 1'b1 - OCC_W'(do_evict);
      if (cmd.op != OP_NONE)      settle_r <= '0;
      else if (settle_r != SETTLED) settle_r <= settle_r + 1'b1;
      if (go)                out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_mode_r  <= in_ch.mode;
      req_key_r   <= in_ch.key;
      req_value_r <= in_ch.value;
    end
    if (go) begin
      out_hit_r     <= any_hit;
      out_value_r   <= (any_hit && !req_mode_r) ? hit_val : '0;
      out_evicted_r <= do_evict;
      out_ekey_r    <= do_evict ? c_bk[CAPACITY] : '0;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.evicted     = out_evicted_r;
  assign out_ch.evicted_key = out_ekey_r;

  a_no_dup_keys: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(hit_vec) <= 1)
    else $error("key held by more than one entry");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= SETTLED)
    else $error("occupancy above capacity");

  a_insert_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INSERT) |-> (settle_r == SETTLED && (do_evict || c_ff[CAPACITY])))
    else $error("insert without settled chain or free slot");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("hit and eviction in one result");

endmodule : lfu_cache_lru_tiebreak
`default_nettype wire
